FILE: src/mbpdu_pkg.sv
`timescale 1ns / 1ps
package mbpdu_pkg;
	localparam int INPUT_DEPTH = 2048;
	localparam int ADDR_W = $clog2(INPUT_DEPTH);

	localparam logic [15:0] MAX_BITS = 16'd2000;
	localparam logic [15:0] MAX_REGS = 16'd125;
	localparam logic [15:0] COIL_ON = 16'hFF00;
	localparam logic [7:0] EXC_FLAG = 8'h80;
	localparam logic [16:0] PF_DOC = 17'd1109;
	localparam logic [16:0] DISCRETE_COUNT = 17'd16;

	localparam logic [7:0] EX_FUNCTION = 8'h01;
	localparam logic [7:0] EX_ADDRESS = 8'h02;
	localparam logic [7:0] EX_VALUE = 8'h03;

	localparam logic [7:0] FC_READ_COILS = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FC_READ_INPUT = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL = 8'd5;
	localparam logic [7:0] FC_WRITE_REG = 8'd6;

	localparam logic REG_ADDRESS_BASE = 1'b0;
	localparam logic REG_UNIT_ID = 1'b1;

	typedef struct packed {
		logic clr;
		logic capture;
		logic eval;
		logic put;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic foreign;
		logic last_byte;
	} sts_t;
endpackage

FILE: src/modbus_pdu_register_server.sv
`timescale 1ns / 1ps
// Modbus request PDU server. After reset the block is busy while a sweep
// zeroes the input register image, one word a cycle. A load item is
// written into the image while the block stays idle. A request gives a
// response of N bytes (2 to 252), built one byte at a time: a fetch state
// for the image read and a put state to pack the byte. A request with a
// foreign unit id gives no result. Each chunk of up to 4 bytes appears on
// the result ports for one cycle with valid high; the receiver
// cannot stall, so it must take every chunk as it comes.
module modbus_pdu_register_server import mbpdu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        opcode,
	input  logic [7:0]  unit_ident,
	input  logic [7:0]  function_code,
	input  logic [7:0]  pdu_length,
	input  logic [15:0] first_word,
	input  logic [15:0] second_word,
	output logic        valid,
	output logic [31:0] response_bytes,
	output logic [2:0]  byte_count,
	output logic        last,
	output logic        is_exception
);
	cmd_t cmd;
	sts_t sts;

	mbpdu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	mbpdu_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.opcode(opcode), .unit_ident(unit_ident), .function_code(function_code),
		.pdu_length(pdu_length), .first_word(first_word), .second_word(second_word),
		.valid(valid), .response_bytes(response_bytes), .byte_count(byte_count),
		.last(last), .is_exception(is_exception)
	);
endmodule

FILE: src/mbpdu_ctrl.sv
`timescale 1ns / 1ps
module mbpdu_ctrl import mbpdu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic opcode,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);
	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_EVAL  = 5'b00100,
		S_FETCH = 5'b01000,
		S_PUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.capture = start;
				if (start && !opcode) state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = sts.foreign ? S_IDLE : S_FETCH;
			end
			S_FETCH: state_d = S_PUT;
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = sts.last_byte ? S_IDLE : S_FETCH;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	a_eval_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |=> state_q == S_FETCH || state_q == S_IDLE)
		else $error("bad state after eval");
endmodule

FILE: src/mbpdu_dp.sv
`timescale 1ns / 1ps
module mbpdu_dp import mbpdu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        opcode,
	input  logic [7:0]  unit_ident,
	input  logic [7:0]  function_code,
	input  logic [7:0]  pdu_length,
	input  logic [15:0] first_word,
	input  logic [15:0] second_word,
	output logic        valid,
	output logic [31:0] response_bytes,
	output logic [2:0]  byte_count,
	output logic        last,
	output logic        is_exception
);
	logic        base_q;
	logic [7:0]  unit_id_q;
	logic [1:0]  enables_q;
	logic [15:0] setp_q [2];
	logic [15:0] mem [INPUT_DEPTH];
	logic [15:0] rd_q;
	logic [ADDR_W-1:0] clr_q;

	logic [7:0]  uid_q, fc_q, plen_q;
	logic [15:0] w1_q, w2_q;
	logic        exc_q;
	logic [7:0]  exc_code_q, len_q, pos_q;
	logic [31:0] chunk_q;
	logic [1:0]  cnt_q;
	logic        valid_q, last_q, is_exc_q;
	logic [31:0] resp_q;
	logic [2:0]  count_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 1'b1;
			unit_id_q <= 8'd1;
		end else if (cfg_we) begin
			if (cfg_index == REG_ADDRESS_BASE) base_q <= cfg_data[0];
			else unit_id_q <= cfg_data;
		end
	end

	// register image addresses
	logic [15:0] coil_p, coil_q, hold_p, hold_q;
	logic [16:0] in_count;
	always_comb begin
		coil_p = 16'd11 - 16'(base_q);
		coil_q = 16'd15 - 16'(base_q);
		hold_p = 16'd13 - 16'(base_q);
		hold_q = 16'd17 - 16'(base_q);
		in_count = PF_DOC + 17'd2 - 17'(base_q);
		if (in_count > 17'(INPUT_DEPTH)) in_count = 17'(INPUT_DEPTH);
	end

	// request check
	logic        e_exc;
	logic [7:0]  e_code, e_len;
	logic [16:0] e_sum, e_lim;
	logic [15:0] e_nb;
	always_comb begin
		e_exc = 1'b0;
		e_code = EX_FUNCTION;
		e_len = 8'd5;
		e_sum = 17'(w1_q) + 17'(w2_q);
		e_nb = (w2_q + 16'd7) >> 3;
		e_lim = 17'd0;
		if (plen_q == 8'd0 || fc_q < FC_READ_COILS || fc_q > FC_WRITE_REG) begin
			e_exc = 1'b1;
			e_code = EX_FUNCTION;
		end else if (plen_q < 8'd5) begin
			e_exc = 1'b1;
			e_code = EX_VALUE;
		end else begin
			case (fc_q)
				FC_READ_COILS, FC_READ_DISCRETE: begin
					e_lim = (fc_q == FC_READ_COILS) ? 17'd16 - 17'(base_q) : DISCRETE_COUNT;
					e_len = 8'd2 + e_nb[7:0];
					if (w2_q < 16'd1 || w2_q > MAX_BITS) begin
						e_exc = 1'b1;
						e_code = EX_VALUE;
					end else if (e_sum > e_lim) begin
						e_exc = 1'b1;
						e_code = EX_ADDRESS;
					end
				end
				FC_READ_HOLDING, FC_READ_INPUT: begin
					e_lim = (fc_q == FC_READ_HOLDING) ? 17'd18 - 17'(base_q) : in_count;
					e_len = 8'd2 + {w2_q[6:0], 1'b0};
					if (w2_q < 16'd1 || w2_q > MAX_REGS) begin
						e_exc = 1'b1;
						e_code = EX_VALUE;
					end else if (e_sum > e_lim) begin
						e_exc = 1'b1;
						e_code = EX_ADDRESS;
					end
				end
				FC_WRITE_COIL: begin
					if (w2_q != 16'd0 && w2_q != COIL_ON) begin
						e_exc = 1'b1;
						e_code = EX_VALUE;
					end else if (w1_q != coil_p && w1_q != coil_q) begin
						e_exc = 1'b1;
						e_code = EX_ADDRESS;
					end
				end
				default: begin
					if (w1_q != hold_p && w1_q != hold_q) begin
						e_exc = 1'b1;
						e_code = EX_ADDRESS;
					end
				end
			endcase
		end
		if (e_exc) e_len = 8'd2;
	end

	// byte at the current position
	logic [7:0]  j, b;
	logic [15:0] widx, wa, word;
	logic [16:0] bi, ba;
	logic        bit_v;
	always_comb begin
		j = pos_q - 8'd2;
		widx = 16'(j >> 1);
		wa = w1_q + widx;
		b = 8'd0;
		bi = 17'd0;
		ba = 17'd0;
		bit_v = 1'b0;
		if (fc_q == FC_READ_INPUT) word = rd_q;
		else if (wa == hold_p) word = setp_q[0];
		else if (wa == hold_q) word = setp_q[1];
		else word = 16'd0;
		if (exc_q) begin
			b = (pos_q == 8'd0) ? (fc_q | EXC_FLAG) : exc_code_q;
		end else if (pos_q == 8'd0) begin
			b = fc_q;
		end else if (fc_q == FC_WRITE_COIL || fc_q == FC_WRITE_REG) begin
			case (pos_q)
				8'd1: b = w1_q[15:8];
				8'd2: b = w1_q[7:0];
				8'd3: b = w2_q[15:8];
				default: b = w2_q[7:0];
			endcase
		end else if (pos_q == 8'd1) begin
			b = len_q - 8'd2;
		end else if (fc_q == FC_READ_HOLDING || fc_q == FC_READ_INPUT) begin
			b = j[0] ? word[7:0] : word[15:8];
		end else begin
			for (int k = 0; k < 8; k++) begin
				bi = {6'd0, j, 3'd0} + 17'(k);
				ba = 17'(w1_q) + bi;
				bit_v = (fc_q == FC_READ_COILS) && (bi < 17'(w2_q)) &&
					((ba == 17'(coil_p) && enables_q[0]) ||
					 (ba == 17'(coil_q) && enables_q[1]));
				b[k] = bit_v;
			end
		end
	end

	logic [31:0] chunk_n;
	assign chunk_n = chunk_q | ({b, 24'd0} >> {cnt_q, 3'b000});

	assign sts.clear_last = (clr_q == ADDR_W'(INPUT_DEPTH - 1));
	assign sts.foreign = (uid_q != unit_id_q) && (uid_q != 8'h00) && (uid_q != 8'hFF);
	assign sts.last_byte = (pos_q + 8'd1 == len_q);

	// input register image, zeroed by a sweep after reset
	logic [ADDR_W-1:0] rd_addr;
	assign rd_addr = wa[ADDR_W-1:0];
	always_ff @(posedge clk) begin
		if (cmd.clr) mem[clr_q] <= 16'd0;
		else if (cmd.capture && opcode && (32'(first_word) < INPUT_DEPTH))
			mem[first_word[ADDR_W-1:0]] <= second_word;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			enables_q <= 2'b00;
			setp_q[0] <= 16'd0;
			setp_q[1] <= 16'd0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cmd.eval && !sts.foreign && !e_exc) begin
				if (fc_q == FC_WRITE_COIL) begin
					if (w1_q == coil_p) enables_q[0] <= (w2_q != 16'd0);
					else enables_q[1] <= (w2_q != 16'd0);
				end else if (fc_q == FC_WRITE_REG) begin
					if (w1_q == hold_p) setp_q[0] <= w2_q;
					else setp_q[1] <= w2_q;
				end
			end
			if (cmd.put && (cnt_q == 2'd3 || sts.last_byte)) valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			uid_q <= unit_ident;
			fc_q <= function_code;
			plen_q <= pdu_length;
			w1_q <= first_word;
			w2_q <= second_word;
		end
		if (cmd.eval) begin
			exc_q <= e_exc;
			exc_code_q <= e_code;
			len_q <= e_len;
			pos_q <= 8'd0;
			chunk_q <= 32'd0;
			cnt_q <= 2'd0;
		end
		if (cmd.put) begin
			pos_q <= pos_q + 8'd1;
			if (cnt_q == 2'd3 || sts.last_byte) begin
				resp_q <= chunk_n;
				count_q <= 3'(cnt_q) + 3'd1;
				last_q <= sts.last_byte;
				is_exc_q <= exc_q;
				chunk_q <= 32'd0;
				cnt_q <= 2'd0;
			end else begin
				chunk_q <= chunk_n;
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	assign valid = valid_q;
	assign response_bytes = resp_q;
	assign byte_count = count_q;
	assign last = last_q;
	assign is_exception = is_exc_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> byte_count >= 3'd1 && byte_count <= 3'd4)
		else $error("byte count out of range");
	a_exc_short: assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_exception |-> last && byte_count == 3'd2)
		else $error("exception response not one two-byte chunk");
	a_partial_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && byte_count != 3'd4 |-> last)
		else $error("partial chunk before end of response");
endmodule
